>>> hdl/orl_pkg.sv
// Shared types, field widths and operation and status codes of the ordered record list.
`timescale 1ns / 1ps

package orl_pkg;

    localparam int DEFAULT_CAPACITY = 16;

    localparam int FUNC_W   = 3;
    localparam int KEY_W    = 32;
    localparam int TAG_W    = 16;
    localparam int PAY_W    = 32;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;
    localparam int HELD_W   = 5;

    // Operation codes carried in the func field.
    localparam logic [FUNC_W-1:0] FN_INS_FIRST = 3'd0;
    localparam logic [FUNC_W-1:0] FN_INS_LAST  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_INS_UNIQ  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_INS_AT    = 3'd3;
    localparam logic [FUNC_W-1:0] FN_DEL_KEY   = 3'd4;
    localparam logic [FUNC_W-1:0] FN_EXTRACT   = 3'd5;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DUP  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [KEY_W-1:0]  record_key;
        logic [TAG_W-1:0]  record_tag;
        logic [PAY_W-1:0]  record_payload;
        logic [POS_W-1:0]  position;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [KEY_W-1:0]    out_key;
        logic [TAG_W-1:0]    out_tag;
        logic [PAY_W-1:0]    out_payload;
        logic [HELD_W-1:0]   entries_held;
        logic                last;
    } rsp_t;

    // One stored record as it sits in the record memory.
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
        logic [PAY_W-1:0] payload;
    } rec_t;

endpackage

>>> hdl/orl_store.sv
// Record memory: one write port and one read port with registered read data.
`timescale 1ns / 1ps

module orl_store #(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic            aclk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  orl_pkg::rec_t   wr_data,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    output orl_pkg::rec_t   rd_data
);
    import orl_pkg::*;

    rec_t mem [DEPTH];
    rec_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/ordered_record_list_top.sv
// Top level of the ordered record list: sequencer around a single record memory.
`timescale 1ns / 1ps

//  Channel  Direction  Handshake           Transaction
//  s_       in         s_valid / s_ready   one operation (orl_pkg::req_t)
//  m_       out        m_valid / m_ready   one result record (orl_pkg::rsp_t)
//
// One operation at a time; s_ready is high only while the sequencer is idle, and
// records live in one memory with a registered read, walked one entry per cycle
// unless the m_ channel stalls. A plain insert moves the records from its position
// to the tail; a delete or insert-unique scans the list, an extract scans it and
// walks it again; a plain insert into a full list or an unknown code goes straight
// to the result. Reset (aresetn low, synchronous) empties the list, with no clearing
// pass. A stalled m_ channel holds an extract walk, or any final result, until taken.

module ordered_record_list_top #(
    parameter int CAPACITY = orl_pkg::DEFAULT_CAPACITY
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  orl_pkg::req_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output orl_pkg::rsp_t  m_data
);
    import orl_pkg::*;

    // IDX_W addresses the memory; CNT_W also holds the full count.
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int PW    = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_SCAN    = 6'b000010,
        S_SHIFT   = 6'b000100,
        S_COMPACT = 6'b001000,
        S_PUT     = 6'b010000,
        S_RESP    = 6'b100000
    } state_t;

    state_t                state_reg,     state_next;
    logic [CNT_W-1:0]      count_reg,     count_next;
    logic [FUNC_W-1:0]     op_reg,        op_next;
    logic [KEY_W-1:0]      key_reg,       key_next;
    logic [TAG_W-1:0]      tag_reg,       tag_next;
    logic [PAY_W-1:0]      pay_reg,       pay_next;
    logic [IDX_W-1:0]      tgt_reg,       tgt_next;
    logic [CNT_W-1:0]      rd_ptr_reg,    rd_ptr_next;
    logic [IDX_W-1:0]      rd_idx_reg,    rd_idx_next;
    logic                  rvld_reg,      rvld_next;
    logic [CNT_W-1:0]      wr_ptr_reg,    wr_ptr_next;
    logic [CNT_W-1:0]      shift_cnt_reg, shift_cnt_next;
    logic [CNT_W-1:0]      nmatch_reg,    nmatch_next;
    logic [CNT_W-1:0]      rem_reg,       rem_next;
    rec_t                  hit_reg,       hit_next;
    logic [STATUS_W-1:0]   st_reg,        st_next;
    logic                  m_valid_reg,   m_valid_next;
    rsp_t                  m_data_reg,    m_data_next;

    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    rec_t                  mem_wdata;
    logic                  mem_re;
    logic [IDX_W-1:0]      mem_raddr;
    rec_t                  mem_rdata;

    logic                  out_free;
    logic                  in_take;
    logic [CNT_W-1:0]      ins_pos;
    logic                  stop_scan;
    logic                  stall;
    logic                  walk_done;

    orl_store #(
        .DEPTH (CAPACITY),
        .AW    (IDX_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign in_take  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // A walk is over once every issued read has come back and no read is left.
    assign walk_done = (rd_ptr_reg == count_reg) && !rvld_reg;

    // Target slot of a plain insert, with the position clamped to the count.
    always_comb begin
        unique case (s_data.func)
            FN_INS_FIRST: ins_pos = '0;
            FN_INS_AT: begin
                if (PW'(s_data.position) > PW'(count_reg)) begin
                    ins_pos = count_reg;
                end else begin
                    ins_pos = CNT_W'(s_data.position);
                end
            end
            default: ins_pos = count_reg;
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        tag_next       = tag_reg;
        pay_next       = pay_reg;
        tgt_next       = tgt_reg;
        rd_ptr_next    = rd_ptr_reg;
        rd_idx_next    = rd_idx_reg;
        rvld_next      = 1'b0;
        wr_ptr_next    = wr_ptr_reg;
        shift_cnt_next = shift_cnt_reg;
        nmatch_next    = nmatch_reg;
        rem_next       = rem_reg;
        hit_next       = hit_reg;
        st_next        = st_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = mem_rdata;
        mem_re         = 1'b0;
        mem_raddr      = rd_ptr_reg[IDX_W-1:0];
        stop_scan      = 1'b0;
        stall          = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (in_take) begin
                    op_next     = s_data.func;
                    key_next    = s_data.record_key;
                    tag_next    = s_data.record_tag;
                    pay_next    = s_data.record_payload;
                    hit_next    = '0;
                    st_next     = ST_OK;
                    rd_ptr_next = '0;
                    nmatch_next = '0;
                    unique case (s_data.func)
                        FN_INS_FIRST, FN_INS_LAST, FN_INS_AT: begin
                            if (count_reg == CNT_W'(CAPACITY)) begin
                                st_next    = ST_FULL;
                                state_next = S_RESP;
                            end else begin
                                // Walk downward from the tail, opening a gap at the target.
                                tgt_next       = ins_pos[IDX_W-1:0];
                                shift_cnt_next = count_reg - ins_pos;
                                rd_ptr_next    = count_reg - CNT_W'(1);
                                state_next     = (count_reg != ins_pos) ? S_SHIFT : S_PUT;
                            end
                        end
                        FN_INS_UNIQ, FN_DEL_KEY, FN_EXTRACT: begin
                            state_next = S_SCAN;
                        end
                        default: begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (rvld_reg) begin
                    if (op_reg == FN_INS_UNIQ && mem_rdata.key == key_reg) begin
                        stop_scan  = 1'b1;
                        st_next    = ST_DUP;
                        state_next = S_RESP;
                    end else if (op_reg == FN_DEL_KEY && mem_rdata.key == key_reg) begin
                        // First hit: keep the record, then close the gap behind it.
                        stop_scan   = 1'b1;
                        hit_next    = mem_rdata;
                        wr_ptr_next = CNT_W'(rd_idx_reg);
                        rd_ptr_next = CNT_W'(rd_idx_reg) + CNT_W'(1);
                        state_next  = S_COMPACT;
                    end else if (op_reg == FN_EXTRACT && mem_rdata.tag == tag_reg) begin
                        nmatch_next = nmatch_reg + CNT_W'(1);
                    end
                end
                if (!stop_scan) begin
                    if (rd_ptr_reg < count_reg) begin
                        mem_re      = 1'b1;
                        rd_idx_next = rd_ptr_reg[IDX_W-1:0];
                        rd_ptr_next = rd_ptr_reg + CNT_W'(1);
                        rvld_next   = 1'b1;
                    end else if (walk_done) begin
                        priority case (op_reg)
                            FN_INS_UNIQ: begin
                                if (count_reg == CNT_W'(CAPACITY)) begin
                                    st_next    = ST_FULL;
                                    state_next = S_RESP;
                                end else begin
                                    tgt_next   = count_reg[IDX_W-1:0];
                                    state_next = S_PUT;
                                end
                            end
                            FN_EXTRACT: begin
                                if (nmatch_reg == '0) begin
                                    st_next    = ST_MISS;
                                    state_next = S_RESP;
                                end else begin
                                    rd_ptr_next = '0;
                                    wr_ptr_next = '0;
                                    rem_next    = nmatch_reg;
                                    state_next  = S_COMPACT;
                                end
                            end
                            default: begin
                                st_next    = ST_MISS;
                                state_next = S_RESP;
                            end
                        endcase
                    end
                end
            end

            S_SHIFT: begin
                if (rvld_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = rd_idx_reg + IDX_W'(1);
                    mem_wdata = mem_rdata;
                end
                if (shift_cnt_reg != '0) begin
                    mem_re         = 1'b1;
                    rd_idx_next    = rd_ptr_reg[IDX_W-1:0];
                    rd_ptr_next    = rd_ptr_reg - CNT_W'(1);
                    shift_cnt_next = shift_cnt_reg - CNT_W'(1);
                    rvld_next      = 1'b1;
                end else if (!rvld_reg) begin
                    state_next = S_PUT;
                end
            end

            S_COMPACT: begin
                if (rvld_reg) begin
                    if (op_reg == FN_EXTRACT && mem_rdata.tag == tag_reg) begin
                        if (out_free) begin
                            m_valid_next             = 1'b1;
                            m_data_next.status       = ST_OK;
                            m_data_next.out_key      = mem_rdata.key;
                            m_data_next.out_tag      = mem_rdata.tag;
                            m_data_next.out_payload  = mem_rdata.payload;
                            m_data_next.entries_held = HELD_W'(count_reg - nmatch_reg);
                            m_data_next.last         = (rem_reg == CNT_W'(1));
                            rem_next                 = rem_reg - CNT_W'(1);
                        end else begin
                            stall = 1'b1;
                        end
                    end else begin
                        mem_we      = 1'b1;
                        mem_waddr   = wr_ptr_reg[IDX_W-1:0];
                        mem_wdata   = mem_rdata;
                        wr_ptr_next = wr_ptr_reg + CNT_W'(1);
                    end
                end
                if (stall) begin
                    // Hold the read data in place until the output register frees up.
                    rvld_next = 1'b1;
                end else if (rd_ptr_reg < count_reg) begin
                    mem_re      = 1'b1;
                    rd_ptr_next = rd_ptr_reg + CNT_W'(1);
                    rvld_next   = 1'b1;
                end else if (walk_done) begin
                    count_next = wr_ptr_reg;
                    if (op_reg == FN_DEL_KEY) begin
                        st_next    = ST_OK;
                        state_next = S_RESP;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_PUT: begin
                mem_we            = 1'b1;
                mem_waddr         = tgt_reg;
                mem_wdata.key     = key_reg;
                mem_wdata.tag     = tag_reg;
                mem_wdata.payload = pay_reg;
                count_next        = count_reg + CNT_W'(1);
                state_next        = S_RESP;
            end

            S_RESP: begin
                if (out_free) begin
                    m_valid_next             = 1'b1;
                    m_data_next.status       = st_reg;
                    m_data_next.out_key      = hit_reg.key;
                    m_data_next.out_tag      = hit_reg.tag;
                    m_data_next.out_payload  = hit_reg.payload;
                    m_data_next.entries_held = HELD_W'(count_reg);
                    m_data_next.last         = 1'b1;
                    state_next               = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            rvld_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rvld_reg    <= rvld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        tag_reg       <= tag_next;
        pay_reg       <= pay_next;
        tgt_reg       <= tgt_next;
        rd_ptr_reg    <= rd_ptr_next;
        rd_idx_reg    <= rd_idx_next;
        wr_ptr_reg    <= wr_ptr_next;
        shift_cnt_reg <= shift_cnt_next;
        nmatch_reg    <= nmatch_next;
        rem_reg       <= rem_next;
        hit_reg       <= hit_next;
        st_reg        <= st_next;
        m_data_reg    <= m_data_next;
    end

    // The list never holds more records than the memory has entries.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("record count exceeds capacity");

    // Walks never read and write the same entry in one cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_we && mem_re && mem_waddr == mem_raddr))
        else $error("read and write of the same entry in one cycle");

    // The count only moves when a record is placed or a walk closes gaps.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(count_reg) |-> ($past(state_reg) == S_PUT || $past(state_reg) == S_COMPACT))
        else $error("record count changed outside an insert or a removal");

    // A new result is never loaded over one that is still waiting to be taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> $stable(m_data_reg))
        else $error("pending result overwritten");

endmodule
